// File: rtl/core/bia_pkg.sv
// Shared constants, operator codes and pipeline sideband type for the integer ALU.
// No dependencies; used by bia_divider and bytecode_integer_alu.
package bia_pkg;

   localparam int DATA_W     = 32;
   localparam int CMD_W      = 6;
   localparam int DIV_STAGES = DATA_W;

   localparam logic [CMD_W-1:0] OP_ADD = 6'd0;
   localparam logic [CMD_W-1:0] OP_SUB = 6'd1;
   localparam logic [CMD_W-1:0] OP_MUL = 6'd2;
   localparam logic [CMD_W-1:0] OP_DIV = 6'd3;
   localparam logic [CMD_W-1:0] OP_REM = 6'd4;
   localparam logic [CMD_W-1:0] OP_AND = 6'd5;
   localparam logic [CMD_W-1:0] OP_OR  = 6'd6;
   localparam logic [CMD_W-1:0] OP_XOR = 6'd7;
   localparam logic [CMD_W-1:0] OP_SHL = 6'd8;
   localparam logic [CMD_W-1:0] OP_SHR = 6'd9;
   localparam logic [CMD_W-1:0] ALIAS_LO = 6'd20;
   localparam logic [CMD_W-1:0] ALIAS_HI = 6'd29;
   localparam logic [CMD_W-1:0] OP_EQ  = 6'd40;
   localparam logic [CMD_W-1:0] OP_NE  = 6'd41;
   localparam logic [CMD_W-1:0] OP_LE  = 6'd42;
   localparam logic [CMD_W-1:0] OP_LT  = 6'd43;
   localparam logic [CMD_W-1:0] OP_GE  = 6'd44;
   localparam logic [CMD_W-1:0] OP_GT  = 6'd45;
   localparam logic [CMD_W-1:0] OP_LAND = 6'd60;
   localparam logic [CMD_W-1:0] OP_LOR  = 6'd61;

   typedef enum logic [1:0] {
      CLS_OTHER,
      CLS_BOOL,
      CLS_DIV,
      CLS_REM
   } cls_type;

   typedef struct packed {
      cls_type           cls;
      logic [DATA_W-1:0] result;
      logic              bad;
      logic              neg_quo;
      logic              neg_rem;
   } side_type;

endpackage

// File: rtl/core/bia_divider.sv
// Pipelined unsigned restoring divider, one quotient bit per stage.
// Depends on bia_pkg for widths and the sideband type carried with each item.
module bia_divider (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         in_valid,
   input  logic [bia_pkg::DATA_W-1:0]   in_dividend,
   input  logic [bia_pkg::DATA_W-1:0]   in_divisor,
   input  bia_pkg::side_type            in_side,
   output logic                         out_valid,
   output logic [bia_pkg::DATA_W-1:0]   out_quotient,
   output logic [bia_pkg::DATA_W-1:0]   out_remainder,
   output bia_pkg::side_type            out_side
);

   localparam int W = bia_pkg::DATA_W;
   localparam int N = bia_pkg::DIV_STAGES;

   logic                valid_ff [N];
   logic [W-1:0]        rem_ff   [N];
   logic [W-1:0]        quo_ff   [N];
   logic [W-1:0]        dvs_ff   [N];
   bia_pkg::side_type   side_ff  [N];

   for (genvar i = 0; i < N; i++) begin : g_stage
      logic              valid_src;
      logic [W-1:0]      rem_src, quo_src, dvs_src;
      bia_pkg::side_type side_src;
      logic [W:0]        trial;
      logic              fits;
      logic [W-1:0]      rem_in, quo_in;

      if (i == 0) begin : g_first
         assign valid_src = in_valid;
         assign rem_src   = '0;
         assign quo_src   = in_dividend;
         assign dvs_src   = in_divisor;
         assign side_src  = in_side;
      end else begin : g_next
         assign valid_src = valid_ff[i-1];
         assign rem_src   = rem_ff[i-1];
         assign quo_src   = quo_ff[i-1];
         assign dvs_src   = dvs_ff[i-1];
         assign side_src  = side_ff[i-1];
      end

      // shift in the next dividend bit, subtract when it fits
      always_comb begin
         trial  = {rem_src, quo_src[W-1]};
         fits   = (trial >= {1'b0, dvs_src});
         rem_in = fits ? W'(trial - {1'b0, dvs_src}) : trial[W-1:0];
         quo_in = {quo_src[W-2:0], fits};
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[i] <= 1'b0;
         end else begin
            valid_ff[i] <= valid_src;
         end
         rem_ff[i]  <= rem_in;
         quo_ff[i]  <= quo_in;
         dvs_ff[i]  <= dvs_src;
         side_ff[i] <= side_src;
      end
   end

   assign out_valid     = valid_ff[N-1];
   assign out_quotient  = quo_ff[N-1];
   assign out_remainder = rem_ff[N-1];
   assign out_side      = side_ff[N-1];

`ifndef SYNTH
   a_rem_below_divisor: assert property (@(posedge clock) disable iff (reset)
      out_valid && (dvs_ff[N-1] != '0) |-> out_remainder < dvs_ff[N-1])
      else $error("remainder not below divisor");
`endif

endmodule

// File: rtl/core/bytecode_integer_alu.sv
// Integer ALU: add, sub, mul, div, rem, bitwise, shifts, compares, logical and/or.
// One item accepted every cycle, busy stays low.
// Items pass the decode and execute stages, the 32-stage divider pipeline and the output stage to rsp_valid.
// Synchronous active-high reset clears all valid bits; no results follow until new items.
// The receiver cannot stall; every item yields exactly one result strobe.
// Depends on bia_pkg and bia_divider.
module bytecode_integer_alu (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   output logic                              busy,
   input  logic [bia_pkg::CMD_W-1:0]         req_cmd,
   input  logic signed [bia_pkg::DATA_W-1:0] req_left_value,
   input  logic signed [bia_pkg::DATA_W-1:0] req_right_value,
   output logic                              rsp_valid,
   output logic signed [bia_pkg::DATA_W-1:0] rsp_result_value,
   output logic                              rsp_bad_operator
);

   localparam int W = bia_pkg::DATA_W;

   // stage 1: decode
   logic                      s1_valid_ff;
   logic [bia_pkg::CMD_W-1:0] s1_op_ff, s1_op_in;
   logic signed [W-1:0]       s1_a_ff, s1_b_ff;

   assign busy = 1'b0;

   always_comb begin
      s1_op_in = req_cmd;
      if (req_cmd >= bia_pkg::ALIAS_LO && req_cmd <= bia_pkg::ALIAS_HI) begin
         s1_op_in = req_cmd - bia_pkg::ALIAS_LO;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= start && !busy;
      end
      s1_op_ff <= s1_op_in;
      s1_a_ff  <= req_left_value;
      s1_b_ff  <= req_right_value;
   end

   // stage 2: execute everything but the divide
   logic                s2_valid_ff;
   logic [W-1:0]        s2_ma_ff, s2_mb_ff, s2_ma_in, s2_mb_in;
   bia_pkg::side_type   s2_side_ff, s2_side_in;
   logic [4:0]          sh;

   always_comb begin
      sh       = s1_b_ff[4:0];
      s2_ma_in = s1_a_ff[W-1] ? W'(-s1_a_ff) : s1_a_ff;
      s2_mb_in = s1_b_ff[W-1] ? W'(-s1_b_ff) : s1_b_ff;
      s2_side_in.cls     = bia_pkg::CLS_OTHER;
      s2_side_in.result  = '0;
      s2_side_in.bad     = 1'b0;
      s2_side_in.neg_quo = s1_a_ff[W-1] ^ s1_b_ff[W-1];
      s2_side_in.neg_rem = s1_a_ff[W-1];
      case (s1_op_ff)
         bia_pkg::OP_ADD: s2_side_in.result = s1_a_ff + s1_b_ff;
         bia_pkg::OP_SUB: s2_side_in.result = s1_a_ff - s1_b_ff;
         bia_pkg::OP_MUL: s2_side_in.result = W'(s1_a_ff * s1_b_ff);
         bia_pkg::OP_DIV, bia_pkg::OP_REM: begin
            // divide by zero returns the left operand for both
            if (s1_b_ff == '0) begin
               s2_side_in.result = s1_a_ff;
            end else begin
               s2_side_in.cls = (s1_op_ff == bia_pkg::OP_DIV) ? bia_pkg::CLS_DIV
                                                               : bia_pkg::CLS_REM;
            end
         end
         bia_pkg::OP_AND: s2_side_in.result = s1_a_ff & s1_b_ff;
         bia_pkg::OP_OR:  s2_side_in.result = s1_a_ff | s1_b_ff;
         bia_pkg::OP_XOR: s2_side_in.result = s1_a_ff ^ s1_b_ff;
         bia_pkg::OP_SHL: s2_side_in.result = s1_a_ff << sh;
         bia_pkg::OP_SHR: s2_side_in.result = s1_a_ff >>> sh;
         bia_pkg::OP_EQ: begin
            s2_side_in.cls = bia_pkg::CLS_BOOL;
            s2_side_in.result = W'(s1_a_ff == s1_b_ff);
         end
         bia_pkg::OP_NE: begin
            s2_side_in.cls = bia_pkg::CLS_BOOL;
            s2_side_in.result = W'(s1_a_ff != s1_b_ff);
         end
         bia_pkg::OP_LE: begin
            s2_side_in.cls = bia_pkg::CLS_BOOL;
            s2_side_in.result = W'(s1_a_ff <= s1_b_ff);
         end
         bia_pkg::OP_LT: begin
            s2_side_in.cls = bia_pkg::CLS_BOOL;
            s2_side_in.result = W'(s1_a_ff < s1_b_ff);
         end
         bia_pkg::OP_GE: begin
            s2_side_in.cls = bia_pkg::CLS_BOOL;
            s2_side_in.result = W'(s1_a_ff >= s1_b_ff);
         end
         bia_pkg::OP_GT: begin
            s2_side_in.cls = bia_pkg::CLS_BOOL;
            s2_side_in.result = W'(s1_a_ff > s1_b_ff);
         end
         bia_pkg::OP_LAND: begin
            s2_side_in.cls = bia_pkg::CLS_BOOL;
            s2_side_in.result = W'((s1_a_ff != '0) && (s1_b_ff != '0));
         end
         bia_pkg::OP_LOR: begin
            s2_side_in.cls = bia_pkg::CLS_BOOL;
            s2_side_in.result = W'((s1_a_ff != '0) || (s1_b_ff != '0));
         end
         default: s2_side_in.bad = 1'b1;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else begin
         s2_valid_ff <= s1_valid_ff;
      end
      s2_ma_ff   <= s2_ma_in;
      s2_mb_ff   <= s2_mb_in;
      s2_side_ff <= s2_side_in;
   end

   // divider stages; every item rides through them to keep order
   logic              dv_valid;
   logic [W-1:0]      dv_quo, dv_rem;
   bia_pkg::side_type dv_side;

   bia_divider u_div (
      .clock         (clock),
      .reset         (reset),
      .in_valid      (s2_valid_ff),
      .in_dividend   (s2_ma_ff),
      .in_divisor    (s2_mb_ff),
      .in_side       (s2_side_ff),
      .out_valid     (dv_valid),
      .out_quotient  (dv_quo),
      .out_remainder (dv_rem),
      .out_side      (dv_side)
   );

   // output stage: sign fixup and select
   logic                out_valid_ff;
   logic [W-1:0]        out_res_ff, out_res_in;
   logic                out_bad_ff;
   bia_pkg::cls_type    out_cls_ff;

   always_comb begin
      case (dv_side.cls)
         bia_pkg::CLS_DIV: out_res_in = dv_side.neg_quo ? W'(-dv_quo) : dv_quo;
         bia_pkg::CLS_REM: out_res_in = dv_side.neg_rem ? W'(-dv_rem) : dv_rem;
         default:          out_res_in = dv_side.result;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
         out_bad_ff   <= 1'b0;
      end else begin
         out_valid_ff <= dv_valid;
         out_bad_ff   <= dv_valid && dv_side.bad;
      end
      out_res_ff <= out_res_in;
      out_cls_ff <= dv_side.cls;
   end

   assign rsp_valid        = out_valid_ff;
   assign rsp_result_value = out_res_ff;
   assign rsp_bad_operator = out_bad_ff;

`ifndef SYNTH
   a_bad_gives_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_bad_operator |-> rsp_result_value == '0)
      else $error("bad operator with nonzero result");
   a_bad_only_valid: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> !rsp_bad_operator)
      else $error("bad flag without result strobe");
   a_bool_is_bit: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && out_cls_ff == bia_pkg::CLS_BOOL |-> rsp_result_value[W-1:1] == '0)
      else $error("compare result not 0 or 1");
`endif

endmodule
